// File: hdl/rmah_pkg.sv
package rmah_pkg;

    // Field widths of a request and of a result.
    localparam int CELL_W = 10;
    localparam int SIDE_W = 20;
    localparam int H_W    = 31;

    // Number of cells in the height map.
    localparam int NCELLS = 1024;

    // The tree has a power-of-two number of leaves at or above NCELLS.
    localparam int LEAF_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int LEAVES = 1 << LEAF_W;
    localparam int NODE_W = LEAF_W + 1;
    localparam int PTR_W  = NODE_W + 1;

    localparam logic [H_W-1:0] H_MAX = {H_W{1'b1}};

    // One node visit produced by the tree walker.
    typedef struct packed {
        logic              valid;
        logic              canon;
        logic [NODE_W-1:0] node;
    } t_emit;

    // One tree node: the maximum under it and the height assigned to all of it.
    typedef struct packed {
        logic [H_W-1:0] tag;
        logic [H_W-1:0] tmax;
    } t_node;

endpackage

// File: hdl/range_max_assign_height_map.sv
// Channel   Direction  Handshake          Payload
// request   in         start / busy       i_left_cell, i_right_cell, i_side_length
// result    out        o_valid (strobe)   o_landed_top, o_tallest, o_range_error
//
// A request is taken when start is high and busy is low.
// A reversed range, or a range with no existing cell, answers without a tree walk.
// Otherwise a query walk (one tree-memory read per node it visits) is
// followed by an update walk that reads and then rewrites each node it visits.
// The strobe comes when the update walk ends; busy drops with it.
// After reset all 2*leaves entries (2048) of the tree memory are cleared with busy high.
// Each result is shown for one cycle and cannot be stalled.
module range_max_assign_height_map (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rmah_pkg::CELL_W-1:0] i_left_cell,
    input  logic [rmah_pkg::CELL_W-1:0] i_right_cell,
    input  logic [rmah_pkg::SIDE_W-1:0] i_side_length,
    output logic                        o_valid,
    output logic [rmah_pkg::H_W-1:0]    o_landed_top,
    output logic [rmah_pkg::H_W-1:0]    o_tallest,
    output logic                        o_range_error
);
    import rmah_pkg::*;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_QUERY, S_UPD_RD, S_UPD_WR} t_state;

    t_state             r_state;
    logic [NODE_W-1:0]  r_clr;
    logic [CELL_W-1:0]  r_lo;
    logic [CELL_W-1:0]  r_hi;
    logic [SIDE_W-1:0]  r_side;
    logic [H_W-1:0]     r_acc;
    logic [H_W-1:0]     r_top;
    logic [H_W-1:0]     r_tallest;
    logic               r_rd_valid;
    logic               r_rd_canon;
    logic [NODE_W-1:0]  r_node;
    logic               r_canon;
    logic               r_valid;
    logic [H_W-1:0]     r_landed;
    logic               r_err;
    t_node              r_rd_data;

    t_node              mem [2*LEAVES];

    logic [CELL_W-1:0]  in_hi;
    logic               in_rev;
    logic               in_none;
    logic [H_W-1:0]     side_sat;
    logic [H_W:0]       sum;
    logic [H_W-1:0]     acc_next;
    logic [H_W-1:0]     node_val;
    t_emit              emit;
    logic               walk_done;
    logic               walk_load;
    logic               walk_step;
    logic [CELL_W-1:0]  walk_lo;
    logic [CELL_W-1:0]  walk_hi;
    logic               we;
    logic [NODE_W-1:0]  waddr;
    t_node              wdata;

    // Clip the range to the cells that exist.
    always_comb begin
        if (32'(i_right_cell) >= NCELLS) begin
            in_hi = CELL_W'(NCELLS - 1);
        end else begin
            in_hi = i_right_cell;
        end
    end
    assign in_rev   = i_left_cell > i_right_cell;
    assign in_none  = i_left_cell > in_hi;
    assign side_sat = H_W'(i_side_length);

    // Query accumulation: covering nodes give their maximum, path nodes their tag.
    assign node_val = r_rd_canon ? ((r_rd_data.tmax > r_rd_data.tag) ? r_rd_data.tmax
                                                                     : r_rd_data.tag)
                                 : r_rd_data.tag;
    assign acc_next = (r_rd_valid && (node_val > r_acc)) ? node_val : r_acc;
    assign sum      = {1'b0, r_acc} + (H_W + 1)'(r_side);

    // Walker control.
    assign walk_load = ((r_state == S_IDLE) && start && !in_rev && !in_none)
                    || ((r_state == S_QUERY) && walk_done && !r_rd_valid);
    assign walk_step = (r_state == S_QUERY) || (r_state == S_UPD_RD);
    assign walk_lo   = (r_state == S_IDLE) ? i_left_cell : r_lo;
    assign walk_hi   = (r_state == S_IDLE) ? in_hi : r_hi;

    rmah_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (walk_load),
        .i_lo    (walk_lo),
        .i_hi    (walk_hi),
        .i_step  (walk_step),
        .o_emit  (emit),
        .o_done  (walk_done)
    );

    // Memory write port: clearing pass or update write-back.
    always_comb begin
        we    = 1'b0;
        waddr = r_node;
        wdata = '0;
        if (r_state == S_CLEAR) begin
            we    = 1'b1;
            waddr = r_clr;
        end else if (r_state == S_UPD_WR) begin
            we         = 1'b1;
            wdata.tmax = (r_rd_data.tmax > r_top) ? r_rd_data.tmax : r_top;
            wdata.tag  = (r_canon && (r_top > r_rd_data.tag)) ? r_top : r_rd_data.tag;
        end
    end

    // Tree memory with a registered read.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_data <= mem[emit.node];
    end

    // Control sequence and registered results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_tallest  <= '0;
            r_valid    <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            r_valid    <= 1'b0;
            r_rd_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + NODE_W'(1);
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        if (in_rev) begin
                            r_valid  <= 1'b1;
                            r_landed <= '0;
                            r_err    <= 1'b1;
                        end else if (in_none) begin
                            r_valid  <= 1'b1;
                            r_landed <= side_sat;
                            r_err    <= 1'b0;
                        end else begin
                            r_lo    <= i_left_cell;
                            r_hi    <= in_hi;
                            r_side  <= i_side_length;
                            r_acc   <= '0;
                            r_state <= S_QUERY;
                        end
                    end
                end
                S_QUERY: begin
                    r_acc      <= acc_next;
                    r_rd_valid <= emit.valid && !walk_done;
                    r_rd_canon <= emit.canon;
                    if (walk_done && !r_rd_valid) begin
                        r_top   <= sum[H_W] ? H_MAX : sum[H_W-1:0];
                        r_state <= S_UPD_RD;
                    end
                end
                S_UPD_RD: begin
                    if (emit.valid) begin
                        r_node  <= emit.node;
                        r_canon <= emit.canon;
                        r_state <= S_UPD_WR;
                    end else if (walk_done) begin
                        r_valid  <= 1'b1;
                        r_landed <= r_top;
                        r_err    <= 1'b0;
                        if (r_top > r_tallest) begin
                            r_tallest <= r_top;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_UPD_WR: begin
                    r_state <= S_UPD_RD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_landed_top  = r_landed;
    assign o_range_error = r_err;
    assign o_tallest     = r_tallest;

`ifndef ASSERT_OFF
    // A write-back always follows its own read.
    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD_WR) |-> ($past(r_state) == S_UPD_RD))
        else $error("write-back without read");

    // The tallest height never decreases.
    a_tallest_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_tallest >= $past(r_tallest)))
        else $error("tallest height decreased");

    // A reversed range reports a zero top.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_err) |-> (r_landed == '0))
        else $error("reversed range with nonzero top");

    // A result is only reported while the block is idle.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE))
        else $error("result while still busy");
`endif

endmodule

// File: hdl/rmah_walk.sv
module rmah_walk (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic [rmah_pkg::CELL_W-1:0] i_lo,
    input  logic [rmah_pkg::CELL_W-1:0] i_hi,
    input  logic                       i_step,
    output rmah_pkg::t_emit            o_emit,
    output logic                       o_done
);
    import rmah_pkg::*;

    typedef enum logic [1:0] {W_CANON, W_PATH_A, W_PATH_B, W_DONE} t_phase;

    t_phase            r_phase;
    logic              r_sub;
    logic [PTR_W-1:0]  r_l;
    logic [PTR_W-1:0]  r_r;
    logic [NODE_W-1:0] r_p;
    logic [NODE_W-1:0] r_a_leaf;
    logic [NODE_W-1:0] r_b_leaf;
    logic [PTR_W-1:0]  r_dec;

    // Node offered in the current cycle.
    always_comb begin
        o_emit = '0;
        case (r_phase)
            W_CANON: begin
                o_emit.canon = 1'b1;
                if (!r_sub) begin
                    o_emit.valid = (r_l < r_r) && r_l[0];
                    o_emit.node  = r_l[NODE_W-1:0];
                end else begin
                    o_emit.valid = r_r[0];
                    o_emit.node  = r_dec[NODE_W-1:0];
                end
            end
            W_PATH_A, W_PATH_B: begin
                o_emit.valid = 1'b1;
                o_emit.node  = r_p;
            end
            default: o_emit = '0;
        endcase
    end

    assign r_dec  = r_r[0] ? (r_r - PTR_W'(1)) : r_r;
    assign o_done = (r_phase == W_DONE);

    // Bottom-up walk: covering nodes first, then both boundary leaf paths.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= W_DONE;
            r_sub   <= 1'b0;
        end else if (i_load) begin
            r_phase  <= W_CANON;
            r_sub    <= 1'b0;
            r_l      <= PTR_W'(LEAVES) + PTR_W'(i_lo);
            r_r      <= PTR_W'(LEAVES) + PTR_W'(i_hi) + PTR_W'(1);
            r_a_leaf <= NODE_W'(LEAVES) + NODE_W'(i_lo);
            r_b_leaf <= NODE_W'(LEAVES) + NODE_W'(i_hi);
        end else if (i_step) begin
            case (r_phase)
                W_CANON: begin
                    if (!r_sub) begin
                        if (!(r_l < r_r)) begin
                            r_phase <= W_PATH_A;
                            r_p     <= r_a_leaf;
                        end else begin
                            if (r_l[0]) begin
                                r_l <= r_l + PTR_W'(1);
                            end
                            r_sub <= 1'b1;
                        end
                    end else begin
                        r_l   <= r_l >> 1;
                        r_r   <= r_dec >> 1;
                        r_sub <= 1'b0;
                    end
                end
                W_PATH_A: begin
                    if (r_p == NODE_W'(1)) begin
                        r_phase <= W_PATH_B;
                        r_p     <= r_b_leaf;
                    end else begin
                        r_p <= r_p >> 1;
                    end
                end
                W_PATH_B: begin
                    if (r_p == NODE_W'(1)) begin
                        r_phase <= W_DONE;
                    end else begin
                        r_p <= r_p >> 1;
                    end
                end
                default: r_phase <= W_DONE;
            endcase
        end
    end

endmodule

// File: dv/tb_range_max_assign_height_map.sv
module tb_range_max_assign_height_map;
    import rmah_pkg::*;

    // One request as the sender presents it, with its pacing.
    typedef struct {
        logic [CELL_W-1:0] left_cell;
        logic [CELL_W-1:0] right_cell;
        logic [SIDE_W-1:0] side_length;
        int unsigned       idle_pct;
        bit                drain_first;
    } t_drop;

    // One landing as the block reports it.
    typedef struct {
        logic [H_W-1:0] landed_top;
        logic [H_W-1:0] tallest;
        logic           range_error;
    } t_landing;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [CELL_W-1:0] i_left_cell;
    logic [CELL_W-1:0] i_right_cell;
    logic [SIDE_W-1:0] i_side_length;
    logic              o_valid;
    logic [H_W-1:0]    o_landed_top;
    logic [H_W-1:0]    o_tallest;
    logic              o_range_error;

    t_drop       pending_drops[$];
    t_landing    expected_landings[$];
    t_drop       cur_drop;
    int unsigned n_dropped;
    int unsigned n_landed;
    int unsigned n_errors;
    int unsigned n_reversed;
    int unsigned n_saturated;

    // Predictor state: the height of each cell and the tallest one.
    logic [H_W-1:0] map_height[NCELLS];
    logic [H_W-1:0] map_tallest;

    range_max_assign_height_map u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_left_cell   (i_left_cell),
        .i_right_cell  (i_right_cell),
        .i_side_length (i_side_length),
        .o_valid       (o_valid),
        .o_landed_top  (o_landed_top),
        .o_tallest     (o_tallest),
        .o_range_error (o_range_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Apply one drop to the height map and return what the block should report.
    function automatic t_landing land_drop(t_drop d);
        t_landing       r;
        logic [H_W-1:0] peak;
        logic [63:0]    sum;
        int             hi;
        peak = '0;
        r.range_error = 1'b0;
        if (d.left_cell > d.right_cell) begin
            r.landed_top  = '0;
            r.tallest     = map_tallest;
            r.range_error = 1'b1;
            return r;
        end
        hi = (int'(d.right_cell) >= NCELLS) ? NCELLS - 1 : int'(d.right_cell);
        for (int i = int'(d.left_cell); i <= hi; i++)
            if (map_height[i] > peak) peak = map_height[i];
        sum = 64'(peak) + 64'(d.side_length);
        r.landed_top = (sum > 64'(H_MAX)) ? H_MAX : sum[H_W-1:0];
        if (int'(d.left_cell) <= hi) begin
            for (int i = int'(d.left_cell); i <= hi; i++) map_height[i] = r.landed_top;
            if (r.landed_top > map_tallest) map_tallest = r.landed_top;
        end
        r.tallest = map_tallest;
        return r;
    endfunction

    // Driver: predict each accepted request, then present the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start         <= 1'b0;
            i_left_cell   <= '0;
            i_right_cell  <= '0;
            i_side_length <= '0;
            n_dropped     <= 0;
        end else if (start && busy) begin
            // Hold the request until the block takes it.
        end else begin
            if (start) begin
                t_landing exp_l;
                exp_l = land_drop(cur_drop);
                if (exp_l.range_error) n_reversed++;
                if (exp_l.landed_top == H_MAX) n_saturated++;
                expected_landings.insert(expected_landings.size(), exp_l);
                n_dropped <= n_dropped + 1;
            end
            if (pending_drops.size() == 0 ||
                (pending_drops[0].drain_first && (start || n_dropped != n_landed)) ||
                $urandom_range(99) < pending_drops[0].idle_pct) begin
                start <= 1'b0;
            end else begin
                cur_drop = pending_drops.pop_front();
                start         <= 1'b1;
                i_left_cell   <= cur_drop.left_cell;
                i_right_cell  <= cur_drop.right_cell;
                i_side_length <= cur_drop.side_length;
            end
        end
    end

    // Monitor: compare each result strobe with the oldest expected landing.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            n_landed <= 0;
        end else if (o_valid) begin
            t_landing exp_l;
            n_landed <= n_landed + 1;
            if (expected_landings.size() == 0) begin
                $error("result with no request outstanding");
                n_errors++;
            end else begin
                exp_l = expected_landings.pop_front();
                if (o_landed_top !== exp_l.landed_top) begin
                    $error("landed_top: expected %0d, actual %0d",
                           exp_l.landed_top, o_landed_top);
                    n_errors++;
                end
                if (o_tallest !== exp_l.tallest) begin
                    $error("tallest: expected %0d, actual %0d", exp_l.tallest, o_tallest);
                    n_errors++;
                end
                if (o_range_error !== exp_l.range_error) begin
                    $error("range_error: expected %0d, actual %0d",
                           exp_l.range_error, o_range_error);
                    n_errors++;
                end
            end
        end
    end

    task automatic add_drop(int lc, int rc, int side, int unsigned idle, bit drain);
        t_drop d;
        d.left_cell   = CELL_W'(lc);
        d.right_cell  = CELL_W'(rc);
        d.side_length = SIDE_W'(side);
        d.idle_pct    = idle;
        d.drain_first = drain;
        pending_drops.insert(pending_drops.size(), d);
    endtask

    // Mostly short ranges, some wide ones, and a share of reversed ranges.
    task automatic add_random_drop(int unsigned idle, bit drain);
        int lc;
        int rc;
        int span;
        int side;
        lc   = int'($urandom_range(NCELLS - 1));
        span = ($urandom_range(9) == 0) ? int'($urandom_range(NCELLS - 1))
                                        : int'($urandom_range(15));
        side = ($urandom_range(3) == 0) ? int'($urandom_range(20'hFFFFF))
                                        : int'($urandom_range(255));
        rc   = int'($urandom_range(NCELLS - 1));
        if ($urandom_range(9) == 0) add_drop(lc, rc, side, idle, drain);
        else add_drop(lc, (lc + span > NCELLS - 1) ? NCELLS - 1 : lc + span, side, idle, drain);
    endtask

    initial begin
        int unsigned idle_by_phase[4];
        idle_by_phase = '{0, 57, 0, 35};
        n_errors    = 0;
        n_reversed  = 0;
        n_saturated = 0;
        map_tallest = '0;
        for (int i = 0; i < NCELLS; i++) map_height[i] = '0;

        // Directed: map edges, full range, reversed ranges, zero side, overlaps.
        add_drop(0, 0, 1, 0, 0);
        add_drop(NCELLS - 1, NCELLS - 1, 20'hFFFFF, 0, 0);
        add_drop(0, NCELLS - 1, 3, 0, 0);
        add_drop(NCELLS - 1, 0, 7, 0, 0);
        add_drop(5, 4, 20'hFFFFF, 0, 0);
        add_drop(10, 20, 0, 0, 0);
        add_drop(15, 30, 100, 0, 0);
        add_drop(25, 25, 0, 0, 0);
        add_drop(0, 511, 20'hAAAAA, 0, 0);
        add_drop(512, NCELLS - 1, 20'h55555, 0, 0);
        add_drop(511, 512, 1, 0, 0);
        add_drop(0, NCELLS - 1, 0, 0, 0);
        add_drop(1, 1, 2, 0, 1);

        // Random requests in pacing phases; each phase starts on an empty pipe.
        for (int p = 0; p < 4; p++)
            for (int k = 0; k < 190; k++) add_random_drop(idle_by_phase[p], k == 0);

        // Stack one cell with large sides, then a few more drops.
        for (int k = 0; k < 20; k++) add_drop(300, 300, 20'hFFFFF, 0, k == 0);
        for (int k = 0; k < 10; k++) add_random_drop(35, 0);
        add_drop(290, 310, 20'hFFFFF, 0, 0);

        wait (i_rst_n === 1'b1);
        while (pending_drops.size() != 0 || start || n_dropped != n_landed)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Checked %0d drops (%0d reversed ranges, %0d saturated landings).",
                 n_landed, n_reversed, n_saturated);
        if (n_errors == 0 && expected_landings.size() == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
